// ===== sv/wg26_pkg.sv =====
package wg26_pkg;

    localparam int unsigned FRAME_LEN = 26;
    localparam int unsigned HALF_LEN  = 12;
    localparam int unsigned CODE_W    = 24;
    localparam int unsigned REG_W     = 16;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned BIT_IDX_W = 5;

    localparam logic [REG_W-1:0] PULSE_LEN_RST    = 16'd50;
    localparam logic [REG_W-1:0] BIT_GAP_RST      = 16'd500;
    localparam logic [REG_W-1:0] MSG_GAP_RST      = 16'd20000;
    localparam logic [REG_W-1:0] REPEAT_COUNT_RST = 16'd1;

    localparam logic [IDX_W-1:0] CFG_PULSE_LEN    = 8'd0;
    localparam logic [IDX_W-1:0] CFG_BIT_GAP      = 8'd1;
    localparam logic [IDX_W-1:0] CFG_MSG_GAP      = 8'd2;
    localparam logic [IDX_W-1:0] CFG_REPEAT_COUNT = 8'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2,
        PH_MSG   = 2'd3
    } t_phase;

endpackage

// ===== sv/wiegand26_transmitter.sv =====
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_stall   i_opcode, i_card_code
// out      out  o_out_valid / i_out_stall o_data0_level, o_data1_level, o_busy_res,
//                                         o_start_rejected
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word in, one word out: the sequencer state and the result register
// update in the same edge, so a word is taken every cycle that o_in_stall
// is low. o_in_stall is high only while a result sits in the output register and
// the downstream side stalls it
// i_rst_n is synchronous, active low; registers return to their reset values
// the config port is always ready
module wiegand26_transmitter
    import wg26_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic [CODE_W-1:0]    i_card_code,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_data0_level,
    output logic                 o_data1_level,
    output logic                 o_busy_res,
    output logic                 o_start_rejected,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    logic [REG_W-1:0]     r_pulse_len;
    logic [REG_W-1:0]     r_bit_gap;
    logic [REG_W-1:0]     r_msg_gap;
    logic [REG_W-1:0]     r_repeat_count;

    logic [FRAME_LEN-1:0] r_frame_bits, n_frame_bits;
    logic [BIT_IDX_W-1:0] r_bit_index, n_bit_index;
    t_phase               r_phase, n_phase;
    logic [REG_W-1:0]     r_phase_timer, n_phase_timer;
    logic [REG_W-1:0]     r_repeats_left, n_repeats_left;

    logic                 r_out_valid;
    logic                 r_d0, n_d0;
    logic                 r_d1, n_d1;
    logic                 r_busy;
    logic                 r_rej, n_rej;

    logic                 w_accept;
    logic [REG_W-1:0]     w_pulse_init;
    logic [BIT_IDX_W-1:0] w_bit_pos;
    logic [BIT_IDX_W-1:0] w_bi_inc;
    logic [REG_W-1:0]     w_rl_dec;
    logic [REG_W-1:0]     w_timer_dec;
    logic                 w_drive;
    logic                 w_line_bit;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_pulse_init = (r_pulse_len == '0) ? REG_W'(1) : r_pulse_len;
    assign w_bit_pos    = BIT_IDX_W'(FRAME_LEN - 1) - r_bit_index;
    assign w_bi_inc     = r_bit_index + BIT_IDX_W'(1);
    assign w_rl_dec     = r_repeats_left - REG_W'(1);
    assign w_timer_dec  = r_phase_timer - REG_W'(1);
    assign w_drive      = (r_phase == PH_PULSE) && (r_bit_index < BIT_IDX_W'(FRAME_LEN));
    assign w_line_bit   = r_frame_bits[w_bit_pos];

    always_comb begin
        n_frame_bits   = r_frame_bits;
        n_bit_index    = r_bit_index;
        n_phase        = r_phase;
        n_phase_timer  = r_phase_timer;
        n_repeats_left = r_repeats_left;
        n_d0           = 1'b1;
        n_d1           = 1'b1;
        n_rej          = 1'b0;

        if (i_opcode == OP_SEND) begin
            if (r_phase != PH_IDLE) begin
                n_rej = 1'b1;
                if (w_drive) begin
                    n_d0 = w_line_bit;
                    n_d1 = ~w_line_bit;
                end
            end else begin
                // even parity on top, odd parity at the bottom
                n_frame_bits   = {^i_card_code[CODE_W-1:HALF_LEN], i_card_code,
                                  ~^i_card_code[HALF_LEN-1:0]};
                n_bit_index    = '0;
                n_repeats_left = (r_repeat_count == '0) ? REG_W'(1) : r_repeat_count;
                n_phase        = PH_PULSE;
                n_phase_timer  = w_pulse_init;
            end
        end else if (r_phase != PH_IDLE) begin
            if (w_drive) begin
                n_d0 = w_line_bit;
                n_d1 = ~w_line_bit;
            end
            n_phase_timer = w_timer_dec;
            if (w_timer_dec == '0) begin
                // zero-length gaps fall through to the following phase
                unique case (r_phase)
                    PH_PULSE, PH_GAP: begin
                        if (r_phase == PH_PULSE && r_bit_gap != '0) begin
                            n_phase       = PH_GAP;
                            n_phase_timer = r_bit_gap;
                        end else begin
                            n_bit_index = w_bi_inc;
                            if (w_bi_inc < BIT_IDX_W'(FRAME_LEN)) begin
                                n_phase       = PH_PULSE;
                                n_phase_timer = w_pulse_init;
                            end else if (r_msg_gap != '0) begin
                                n_phase       = PH_MSG;
                                n_phase_timer = r_msg_gap;
                            end else begin
                                n_repeats_left = w_rl_dec;
                                n_bit_index    = '0;
                                if (w_rl_dec != '0) begin
                                    n_phase       = PH_PULSE;
                                    n_phase_timer = w_pulse_init;
                                end else begin
                                    n_phase       = PH_IDLE;
                                    n_phase_timer = '0;
                                end
                            end
                        end
                    end
                    PH_MSG: begin
                        n_repeats_left = w_rl_dec;
                        n_bit_index    = '0;
                        if (w_rl_dec != '0) begin
                            n_phase       = PH_PULSE;
                            n_phase_timer = w_pulse_init;
                        end else begin
                            n_phase       = PH_IDLE;
                            n_phase_timer = '0;
                        end
                    end
                    PH_IDLE: begin
                        n_phase       = PH_IDLE;
                        n_phase_timer = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_len    <= PULSE_LEN_RST;
            r_bit_gap      <= BIT_GAP_RST;
            r_msg_gap      <= MSG_GAP_RST;
            r_repeat_count <= REPEAT_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PULSE_LEN:    r_pulse_len    <= i_cfg_data;
                CFG_BIT_GAP:      r_bit_gap      <= i_cfg_data;
                CFG_MSG_GAP:      r_msg_gap      <= i_cfg_data;
                CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bits   <= '0;
            r_bit_index    <= '0;
            r_phase        <= PH_IDLE;
            r_phase_timer  <= '0;
            r_repeats_left <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_frame_bits   <= n_frame_bits;
                r_bit_index    <= n_bit_index;
                r_phase        <= n_phase;
                r_phase_timer  <= n_phase_timer;
                r_repeats_left <= n_repeats_left;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0   <= 1'b1;
            r_d1   <= 1'b1;
            r_busy <= 1'b0;
            r_rej  <= 1'b0;
        end else if (w_accept) begin
            r_d0   <= n_d0;
            r_d1   <= n_d1;
            r_busy <= (n_phase != PH_IDLE);
            r_rej  <= n_rej;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data0_level    = r_d0;
    assign o_data1_level    = r_d1;
    assign o_busy_res       = r_busy;
    assign o_start_rejected = r_rej;

endmodule

// ===== sv/wg26_checker.sv =====
module wg26_checker
    import wg26_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              o_data0_level,
    input  logic              o_data1_level,
    input  logic              o_busy_res,
    input  logic              o_start_rejected
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_data0_level, o_data1_level, o_busy_res, o_start_rejected}))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // the input side backs up only while a result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free output register");

    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_data0_level || o_data1_level)
        else $error("both data lines low");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_rejected |-> o_busy_res)
        else $error("send rejected while not busy");

endmodule

bind wiegand26_transmitter wg26_checker u_wg26_checker (.*);

// ===== bench/wiegand26_transmitter_test.sv =====
module wiegand26_transmitter_test;
    import wg26_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int FLUSH_LIMIT = 300_000;
    localparam int MAX_WAIT    = 18;

    typedef struct packed {
        logic d0;
        logic d1;
        logic busy;
        logic rej;
    } t_lines;

    localparam t_lines LINES_IDLE     = '{d0: 1'b1, d1: 1'b1, busy: 1'b0, rej: 1'b0};
    localparam t_lines LINES_ARMED    = '{d0: 1'b1, d1: 1'b1, busy: 1'b1, rej: 1'b0};
    localparam t_lines LINES_D0_LOW   = '{d0: 1'b0, d1: 1'b1, busy: 1'b1, rej: 1'b0};
    localparam t_lines LINES_D0_LOW_R = '{d0: 1'b0, d1: 1'b1, busy: 1'b1, rej: 1'b1};

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_REG,
        ROW_RUN
    } t_row_act;

    typedef struct {
        t_row_act          act;
        logic              op;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        logic [REG_W-1:0]  val;
        int                count;
        bit                typed;
        t_lines            want;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_opcode;
    logic [CODE_W-1:0] i_card_code;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_data0_level;
    logic              o_data1_level;
    logic              o_busy_res;
    logic              o_start_rejected;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [REG_W-1:0]  i_cfg_data;

    wiegand26_transmitter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_card_code      (i_card_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_data0_level    (o_data0_level),
        .o_data1_level    (o_data1_level),
        .o_busy_res       (o_busy_res),
        .o_start_rejected (o_start_rejected),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // transmitter shadow: registers and sequencer state
    logic [REG_W-1:0]     pulse_ticks;
    logic [REG_W-1:0]     gap_ticks;
    logic [REG_W-1:0]     idle_ticks;
    logic [REG_W-1:0]     repeat_total;
    logic [FRAME_LEN-1:0] frame_q;
    logic [BIT_IDX_W-1:0] bit_pos;
    t_phase               tx_phase;
    logic [REG_W-1:0]     phase_left;
    logic [REG_W-1:0]     frames_left;

    t_lines line_q[$];
    t_step  plan[$];

    bit     typed_valid;
    t_lines typed_want;
    bit     no_idle;
    int     stall_left;
    int     words_in;
    int     words_out;
    int     reg_writes;
    int     bad_words;
    int     frames_started;
    int     sends_rejected;
    int     busy_words;
    int     cycle_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void start_bit_pulse();
        tx_phase   = PH_PULSE;
        phase_left = (pulse_ticks != 0) ? pulse_ticks : 16'd1;
    endfunction

    // zero-length gaps fall straight through to the following phase
    function automatic void leave_phase();
        bit settled;
        settled = 1'b0;
        while (!settled) begin
            case (tx_phase)
                PH_PULSE: begin
                    tx_phase   = PH_GAP;
                    phase_left = gap_ticks;
                    settled    = (phase_left != 0);
                end
                PH_GAP: begin
                    bit_pos = bit_pos + 1'b1;
                    if (bit_pos < FRAME_LEN) begin
                        start_bit_pulse();
                        settled = 1'b1;
                    end else begin
                        tx_phase   = PH_MSG;
                        phase_left = idle_ticks;
                        settled    = (phase_left != 0);
                    end
                end
                PH_MSG: begin
                    frames_left = frames_left - 1'b1;
                    bit_pos     = '0;
                    if (frames_left != 0) begin
                        start_bit_pulse();
                    end else begin
                        tx_phase   = PH_IDLE;
                        phase_left = '0;
                    end
                    settled = 1'b1;
                end
                default: begin
                    tx_phase   = PH_IDLE;
                    phase_left = '0;
                    settled    = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic t_lines next_line_levels(input logic op, input logic [CODE_W-1:0] code);
        t_lines r;
        r = LINES_IDLE;
        if (op == OP_SEND && tx_phase == PH_IDLE) begin
            frame_q     = {^code[CODE_W-1:HALF_LEN], code, ~^code[HALF_LEN-1:0]};
            bit_pos     = '0;
            frames_left = (repeat_total != 0) ? repeat_total : 16'd1;
            start_bit_pulse();
            frames_started++;
        end else if (tx_phase != PH_IDLE) begin
            if (tx_phase == PH_PULSE && bit_pos < FRAME_LEN) begin
                if (frame_q[FRAME_LEN-1-bit_pos])
                    r.d1 = 1'b0;
                else
                    r.d0 = 1'b0;
            end
            if (op == OP_SEND) begin
                r.rej = 1'b1;
                sends_rejected++;
            end else begin
                phase_left = phase_left - 1'b1;
                if (phase_left == 0)
                    leave_phase();
            end
        end
        r.busy = (tx_phase != PH_IDLE);
        return r;
    endfunction

    function automatic t_step word_row(input logic op, input logic [CODE_W-1:0] code,
                                       input bit typed, input t_lines want);
        t_step s;
        s = '{ROW_WORD, op, code, '0, '0, 0, typed, want};
        return s;
    endfunction

    function automatic t_step reg_row(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        t_step s;
        s = '{ROW_REG, OP_TICK, '0, idx, val, 0, 1'b0, LINES_IDLE};
        return s;
    endfunction

    // count 0 means tick until the frame and its repeats are done
    function automatic t_step run_row(input int n);
        t_step s;
        s = '{ROW_RUN, OP_TICK, '0, '0, '0, n, 1'b0, LINES_IDLE};
        return s;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, line_q.size());
            $display("wiegand26_transmitter_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_lines pred;
        t_lines got;
        t_lines want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PULSE_LEN:    pulse_ticks  = i_cfg_data;
                    CFG_BIT_GAP:      gap_ticks    = i_cfg_data;
                    CFG_MSG_GAP:      idle_ticks   = i_cfg_data;
                    CFG_REPEAT_COUNT: repeat_total = i_cfg_data;
                    default: ;
                endcase
                reg_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                pred = next_line_levels(i_opcode, i_card_code);
                line_q.push_back(typed_valid ? typed_want : pred);
                words_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{d0: o_data0_level, d1: o_data1_level, busy: o_busy_res,
                        rej: o_start_rejected};
                if (line_q.size() == 0) begin
                    if (bad_words < 10)
                        $display("result word %0d arrived with nothing expected", words_out);
                    bad_words++;
                end else begin
                    want = line_q.pop_front();
                    if (got.d0 !== want.d0 || got.d1 !== want.d1 ||
                        got.busy !== want.busy || got.rej !== want.rej) begin
                        if (bad_words < 10)
                            $display("word %0d: expected d0=%b d1=%b busy=%b rej=%b, got d0=%b d1=%b busy=%b rej=%b",
                                     words_out, want.d0, want.d1, want.busy, want.rej,
                                     got.d0, got.d1, got.busy, got.rej);
                        bad_words++;
                    end
                end
                words_out++;
                stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_word(input logic op, input logic [CODE_W-1:0] code,
                             input bit typed, input t_lines want);
        int gap;
        int seen;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_card_code <= code;
        typed_valid <= typed;
        typed_want  <= want;
        seen = words_in;
        do @(negedge i_clk); while (words_in == seen);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (line_q.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        int seen;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        seen = reg_writes;
        do @(negedge i_clk); while (reg_writes == seen);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_ticks(input int n);
        int k;
        bit was_calm;
        was_calm = no_idle;
        no_idle  = 1'b1;
        if (n == 0) begin
            for (k = 0; k < FLUSH_LIMIT && tx_phase != PH_IDLE; k++)
                push_word(OP_TICK, CODE_W'($urandom), 1'b0, LINES_IDLE);
        end else begin
            for (k = 0; k < n; k++)
                push_word(OP_TICK, CODE_W'($urandom), 1'b0, LINES_IDLE);
        end
        no_idle = was_calm;
    endtask

    // short timings keep whole frames and their repeats inside one stretch
    task automatic pick_settings();
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PULSE_LEN, REG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 12)
                                                                        : $urandom_range(0, 2)));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_BIT_GAP, REG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8)
                                                                      : $urandom_range(0, 2)));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_MSG_GAP, REG_W'($urandom_range(0, 5)));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_REPEAT_COUNT, REG_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 7) == 0)
            write_reg(IDX_W'($urandom_range(4, 255)), REG_W'($urandom));
    endtask

    task automatic random_traffic(input int total);
        int span;
        int k;
        logic op;
        logic [CODE_W-1:0] code;
        while (words_in < total) begin
            drain_results();
            pick_settings();
            no_idle = ($urandom_range(0, 3) == 0);
            span = $urandom_range(60, 250);
            for (k = 0; k < span && words_in < total; k++) begin
                if (tx_phase == PH_IDLE)
                    op = ($urandom_range(0, 9) < 7) ? OP_SEND : OP_TICK;
                else
                    op = ($urandom_range(0, 11) == 0) ? OP_SEND : OP_TICK;
                case ($urandom_range(0, 15))
                    0:       code = '0;
                    1:       code = '1;
                    default: code = CODE_W'($urandom);
                endcase
                // idle ticks and rejected sends do not move the block along
                if ((op == OP_SEND) != (tx_phase != PH_IDLE))
                    busy_words++;
                push_word(op, code, 1'b0, LINES_IDLE);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_TICK;
        i_card_code  = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        typed_valid  = 1'b0;
        typed_want   = LINES_IDLE;
        no_idle      = 1'b0;
        stall_left   = 0;
        words_in     = 0;
        words_out    = 0;
        reg_writes   = 0;
        bad_words    = 0;
        frames_started = 0;
        sends_rejected = 0;
        busy_words   = 0;
        cycle_count  = 0;
        pulse_ticks  = PULSE_LEN_RST;
        gap_ticks    = BIT_GAP_RST;
        idle_ticks   = MSG_GAP_RST;
        repeat_total = REPEAT_COUNT_RST;
        frame_q      = '0;
        bit_pos      = '0;
        tx_phase     = PH_IDLE;
        phase_left   = '0;
        frames_left  = '0;

        // reset values: card code ignored on ticks, a zero code leads with DATA0 low
        plan.push_back(word_row(OP_TICK, 24'h000000, 1'b1, LINES_IDLE));
        plan.push_back(word_row(OP_TICK, 24'hFFFFFF, 1'b1, LINES_IDLE));
        plan.push_back(word_row(OP_SEND, 24'h000000, 1'b1, LINES_ARMED));
        plan.push_back(word_row(OP_SEND, 24'hFFFFFF, 1'b1, LINES_D0_LOW_R));
        plan.push_back(word_row(OP_TICK, 24'h000000, 1'b1, LINES_D0_LOW));
        // zero pulse counts as one tick, zero gaps are skipped, all written mid-pulse
        plan.push_back(reg_row(CFG_PULSE_LEN, 16'd0));
        plan.push_back(reg_row(CFG_BIT_GAP, 16'd0));
        plan.push_back(reg_row(CFG_MSG_GAP, 16'd0));
        plan.push_back(run_row(0));
        plan.push_back(reg_row(CFG_REPEAT_COUNT, 16'hFFFF));
        plan.push_back(reg_row(CFG_REPEAT_COUNT, 16'd2));
        plan.push_back(reg_row(8'hFF, 16'hFFFF));
        plan.push_back(reg_row(8'd4, 16'h0000));
        plan.push_back(word_row(OP_SEND, 24'hFFFFFF, 1'b0, LINES_IDLE));
        plan.push_back(word_row(OP_TICK, 24'h123456, 1'b0, LINES_IDLE));
        plan.push_back(word_row(OP_SEND, 24'h800001, 1'b0, LINES_IDLE));
        plan.push_back(run_row(0));
        plan.push_back(reg_row(CFG_PULSE_LEN, 16'd2));
        plan.push_back(reg_row(CFG_BIT_GAP, 16'd1));
        plan.push_back(reg_row(CFG_MSG_GAP, 16'd3));
        plan.push_back(reg_row(CFG_REPEAT_COUNT, 16'd0));
        plan.push_back(word_row(OP_SEND, 24'h0F0F0F, 1'b0, LINES_IDLE));
        plan.push_back(run_row(5));
        plan.push_back(word_row(OP_SEND, 24'hF0F0F0, 1'b0, LINES_IDLE));
        plan.push_back(run_row(0));
        plan.push_back(word_row(OP_TICK, 24'h000000, 1'b1, LINES_IDLE));
        // long pulse, gap and message gap; shorten the bits once the first gap runs
        plan.push_back(reg_row(CFG_PULSE_LEN, 16'd120));
        plan.push_back(reg_row(CFG_BIT_GAP, 16'd90));
        plan.push_back(reg_row(CFG_MSG_GAP, 16'd150));
        plan.push_back(reg_row(CFG_REPEAT_COUNT, 16'd1));
        plan.push_back(word_row(OP_SEND, 24'hA5A5A5, 1'b0, LINES_IDLE));
        plan.push_back(run_row(122));
        plan.push_back(reg_row(CFG_PULSE_LEN, 16'd0));
        plan.push_back(reg_row(CFG_BIT_GAP, 16'd0));
        plan.push_back(run_row(0));
        plan.push_back(word_row(OP_TICK, 24'hFFFFFF, 1'b1, LINES_IDLE));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            case (plan[n].act)
                ROW_WORD: push_word(plan[n].op, plan[n].code, plan[n].typed, plan[n].want);
                ROW_REG: begin
                    drain_results();
                    write_reg(plan[n].idx, plan[n].val);
                end
                default: run_ticks(plan[n].count);
            endcase
        end

        random_traffic(1450);

        drain_results();
        repeat (8) @(negedge i_clk);
        if (line_q.size() != 0) begin
            $display("%0d expected words never arrived", line_q.size());
            bad_words++;
        end
        $display("%0d result words checked over %0d register writes, %0d frames started",
                 words_out, reg_writes, frames_started);
        $display("%0d sends refused while busy, %0d random words kept the sequencer busy",
                 sends_rejected, busy_words);
        if (bad_words == 0)
            $display("wiegand26_transmitter_test OK");
        else
            $display("wiegand26_transmitter_test NOT OK");
        $finish;
    end

endmodule
